// ----- design/spf_pkg.sv -----
// shared types and constants for the speech high-pass prefilter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LOW_W    = 15;
    localparam int ACC_W    = 32;

    // filter coefficients (q13 / q12 style, as in the standard prefilter)
    localparam logic signed [ACC_W-1:0] COEF_B0  = 32'sd1899;
    localparam logic signed [ACC_W-1:0] COEF_A1  = 32'sd7807;
    localparam logic signed [ACC_W-1:0] COEF_A2  = -32'sd3733;

    // limits of the accumulator for which acc * 16 still fits 32 bits
    localparam logic signed [ACC_W-1:0] ACC_MAX  = 32'sd134217727;
    localparam logic signed [ACC_W-1:0] ACC_MIN  = -32'sd134217728;

    // rounding offset for the high half, in accumulator units (0x8000 >> 4)
    localparam logic signed [ACC_W-1:0] RND_OFS  = 32'sd2048;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [LOW_W-1:0]           LOW_MAX    = 15'h7fff;

    // one past output in double precision
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] hi;
        logic [LOW_W-1:0]           lo;
    } dp_sample_t;

    // result of the scaling and saturation stage
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        dp_sample_t                 y_new;
    } sat_result_t;

endpackage : spf_pkg

`default_nettype wire

// ----- design/speech_highpass_prefilter_unit.sv -----
// top level of the speech high-pass prefilter: stream ports, filter state
// depends on spf_pkg, spf_acc and spf_sat
`timescale 1ns / 1ps
`default_nettype none

// second-order 140 hz high-pass with input halving for 16-bit speech samples.
// one sample enters per slave transaction and one filtered sample leaves per
// master transaction, in order; tlast is carried through untouched and does
// not reset the filter. the block takes one sample every clock cycle while
// the receiver keeps up: a sample waits in the input register, then the whole
// accumulate, scale and saturate path runs combinationally into the output
// register while the filter state (two past inputs, two past outputs in
// hi/lo form) is updated in the same edge. m_axis_tvalid rises when the
// sample moves from the input register to the output register, which waits
// while the output register is full and not taken. the rate is set by the
// feedback path through the state registers. while the output register is
// held by a low m_axis_tready the input register fills and then
// s_axis_tready drops; nothing is lost.

module speech_highpass_prefilter_unit
    import spf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample_in
    input  wire logic                s_axis_tlast,   // frame_last_in
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] sample_out
    output logic                     m_axis_tlast    // frame_last_out
);

    // input register
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    // output register
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_sample_reg;
    logic                       out_last_reg;

    // filter state
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    dp_sample_t                 y1_reg;
    dp_sample_t                 y2_reg;

    logic                       s_take;
    logic                       advance;
    logic signed [ACC_W-1:0]    acc;
    sat_result_t                sat_res;

    // item moves from input to output register when the output slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tlast  = out_last_reg;

    spf_acc u_acc
    (
        .x   (in_sample_reg),
        .x1  (x1_reg),
        .x2  (x2_reg),
        .y1  (y1_reg),
        .y2  (y2_reg),
        .acc (acc)
    );

    spf_sat u_sat
    (
        .acc (acc),
        .res (sat_res)
    );

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end
        else
        begin
            if (s_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                x2_reg <= x1_reg;
                x1_reg <= in_sample_reg;
                y2_reg <= y1_reg;
                y1_reg <= sat_res.y_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_sample_reg <= $signed(s_axis_tdata);
            in_last_reg   <= s_axis_tlast;
        end
        if (advance)
        begin
            out_sample_reg <= sat_res.sample;
            out_last_reg   <= in_last_reg;
        end
    end

endmodule : speech_highpass_prefilter_unit

`default_nettype wire

// ----- design/spf_acc.sv -----
// accumulator of the biquad: past outputs and input difference times coefficients
// depends on spf_pkg
`timescale 1ns / 1ps
`default_nettype none

module spf_acc
    import spf_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] x,
    input  wire logic signed [SAMPLE_W-1:0] x1,
    input  wire logic signed [SAMPLE_W-1:0] x2,
    input  wire dp_sample_t                 y1,
    input  wire dp_sample_t                 y2,
    output logic signed [ACC_W-1:0]         acc
);

    logic signed [ACC_W-1:0] y1h_ext;
    logic signed [ACC_W-1:0] y2h_ext;
    logic signed [ACC_W-1:0] y1l_ext;
    logic signed [ACC_W-1:0] y2l_ext;
    logic signed [ACC_W-1:0] dx;
    logic signed [ACC_W-1:0] p_y1h;
    logic signed [ACC_W-1:0] p_y2h;
    logic signed [ACC_W-1:0] p_y1l;
    logic signed [ACC_W-1:0] p_y2l;
    logic signed [ACC_W-1:0] p_dx;

    always_comb
    begin
        y1h_ext = ACC_W'(y1.hi);
        y2h_ext = ACC_W'(y2.hi);
        y1l_ext = $signed({{(ACC_W-LOW_W){1'b0}}, y1.lo});
        y2l_ext = $signed({{(ACC_W-LOW_W){1'b0}}, y2.lo});
        // second difference of the input, at most 18 significant bits
        dx = ACC_W'(x) - (ACC_W'(x1) <<< 1) + ACC_W'(x2);

        p_y1h = y1h_ext * COEF_A1;
        p_y2h = y2h_ext * COEF_A2;
        p_y1l = (y1l_ext * COEF_A1) >>> LOW_W;
        p_y2l = (y2l_ext * COEF_A2) >>> LOW_W;
        p_dx  = dx * COEF_B0;

        acc = p_y1h + p_y1l + p_y2h + p_y2l + p_dx;
    end

endmodule : spf_acc

`default_nettype wire

// ----- design/spf_sat.sv -----
// scaling, rounding and saturation of the accumulator, plus the hi/lo split
// depends on spf_pkg
`timescale 1ns / 1ps
`default_nettype none

module spf_sat
    import spf_pkg::*;
(
    input  wire logic signed [ACC_W-1:0] acc,
    output sat_result_t                  res
);

    logic signed [ACC_W-1:0] rnd;

    always_comb
    begin
        rnd = (acc + RND_OFS) >>> 12;
        if (acc < ACC_MIN)
        begin
            res.sample   = SAMPLE_MIN;
            res.y_new.hi = SAMPLE_MIN;
            res.y_new.lo = '0;
        end
        else if (acc > ACC_MAX)
        begin
            res.sample   = SAMPLE_MAX;
            res.y_new.hi = SAMPLE_MAX;
            res.y_new.lo = LOW_MAX;
        end
        else
        begin
            // rounded high half can only reach 32768 on the top end
            if (rnd > ACC_W'(SAMPLE_MAX))
                res.sample = SAMPLE_MAX;
            else
                res.sample = rnd[SAMPLE_W-1:0];
            res.y_new.hi = acc[SAMPLE_W+11:12];
            res.y_new.lo = {acc[11:0], 3'b000};
        end
    end

endmodule : spf_sat

`default_nettype wire

// ----- test/speech_highpass_prefilter_unit_tb.sv -----
// self-checking testbench for the speech high-pass prefilter stream block
// depends on spf_pkg and speech_highpass_prefilter_unit
`timescale 1ns / 1ps

module speech_highpass_prefilter_unit_tb;
    import spf_pkg::*;

    // cycles without any transaction on either side before the run is abandoned
    localparam int STALL_LIMIT   = 2000;
    // long receiver hold-off used to fill the block and stall its input
    localparam int HOLD_OFF_LEN  = 300;
    // frame length of the speech stream (10 ms at 8 khz)
    localparam int FRAME_LEN     = 80;

    // filter memory: two past inputs, two past outputs in hi/lo form
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1h;
        logic signed [SAMPLE_W-1:0] y2h;
        logic [LOW_W-1:0]           y1l;
        logic [LOW_W-1:0]           y2l;
    } hpf_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } filtered_sample_t;

    // shapes of the random speech stream
    typedef enum int {
        SEG_NOISE,
        SEG_SPEECH,
        SEG_STEP,
        SEG_NYQUIST,
        SEG_QUIET,
        SEG_SILENCE
    } segment_kind_e;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;   // [15:0] sample_in
    logic                s_axis_tlast;   // frame_last_in
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [SAMPLE_W-1:0] m_axis_tdata;   // [15:0] sample_out
    logic                m_axis_tlast;   // frame_last_out

    hpf_state_t       filter_state;
    filtered_sample_t filtered_q[$];
    int               error_count;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               rx_hold_request;
    int               stall_cycles;
    int               frame_pos;

    speech_highpass_prefilter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // -----------------------------------------------------------------
    // filter prediction
    // -----------------------------------------------------------------

    // accumulator of one step, in 64 bits so that nothing wraps; the low
    // words are unsigned q15 fractions, their products are floor-shifted
    function automatic longint hpf_accumulate(input hpf_state_t st,
                                              input logic signed [SAMPLE_W-1:0] x);
        longint y1h;
        longint y1l;
        longint y2h;
        longint y2l;
        longint taps;
        y1h  = st.y1h;
        y1l  = st.y1l;
        y2h  = st.y2h;
        y2l  = st.y2l;
        taps = longint'(x) - 2 * longint'(st.x1) + longint'(st.x2);
        return y1h * COEF_A1 + ((y1l * COEF_A1) >>> 15)
             + y2h * COEF_A2 + ((y2l * COEF_A2) >>> 15)
             + COEF_B0 * taps;
    endfunction

    // one filter step: returns the output sample and moves the memory on
    function automatic void hpf_advance(inout hpf_state_t st,
                                        input logic signed [SAMPLE_W-1:0] x,
                                        output logic signed [SAMPLE_W-1:0] y);
        longint acc;
        longint scaled;
        longint rounded;
        longint high;
        longint low;
        acc = hpf_accumulate(st, x);
        st.x2  = st.x1;
        st.x1  = x;
        st.y2h = st.y1h;
        st.y2l = st.y1l;
        if (acc < ACC_MIN)
        begin
            // negative overflow of the scaled accumulator
            y      = SAMPLE_MIN;
            st.y1h = SAMPLE_MIN;
            st.y1l = '0;
        end
        else if (acc > ACC_MAX)
        begin
            // positive overflow: largest value in both halves
            y      = SAMPLE_MAX;
            st.y1h = SAMPLE_MAX;
            st.y1l = LOW_MAX;
        end
        else
        begin
            scaled  = acc * 16;
            rounded = (scaled + 64'sd32768) >>> 16;
            high    = scaled >>> 16;
            low     = (scaled >>> 1) - high * 32768;
            // rounding can carry past the top of the 16-bit range
            if (rounded > longint'(SAMPLE_MAX))
                rounded = SAMPLE_MAX;
            y      = rounded[SAMPLE_W-1:0];
            st.y1h = high[SAMPLE_W-1:0];
            st.y1l = low[LOW_W-1:0];
        end
    endfunction

    // -----------------------------------------------------------------
    // stimulus side
    // -----------------------------------------------------------------

    // offers one sample, waits for its transaction and books the expected
    // output; entered and left on a falling edge, tvalid is left high so
    // that the caller either offers the next sample or lowers it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample,
                               input logic last);
        filtered_sample_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hpf_advance(filter_state, sample, predicted.sample);
        predicted.last = last;
        filtered_q.push_back(predicted);
        @(negedge clk);
    endtask

    // sender goes quiet until every booked output has been received
    task automatic drain_filter_output();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random speech-like stream built from segments of different shapes;
    // frames of 80 samples, with the odd stray frame marker in between
    task automatic run_speech_traffic(input int n_items);
        segment_kind_e kind;
        int            seg_left;
        int            seg_len;
        int            pos;
        int            pick;
        int            walk;
        int            walk_step;
        int            level_a;
        int            level_b;
        int            amp;
        int            value;
        logic          last;
        seg_left  = 0;
        seg_len   = 1;
        pos       = 0;
        walk      = 0;
        walk_step = 16;
        level_a   = 0;
        level_b   = 0;
        amp       = 0;
        kind      = SEG_SILENCE;
        for (int n = 0; n < n_items; n++)
        begin
            if (seg_left == 0)
            begin
                pick     = $urandom_range(99);
                seg_len  = $urandom_range(4, 40);
                seg_left = seg_len;
                pos      = 0;
                if (pick < 15)
                    kind = SEG_NOISE;
                else if (pick < 50)
                    kind = SEG_SPEECH;
                else if (pick < 70)
                    kind = SEG_STEP;
                else if (pick < 82)
                    kind = SEG_NYQUIST;
                else if (pick < 94)
                    kind = SEG_QUIET;
                else
                    kind = SEG_SILENCE;
                walk_step = 1 << $urandom_range(4, 13);
                // each end of a step sits on a rail half of the time; such steps give the
                // largest excursions of the accumulator
                level_a = ($urandom_range(1) != 0) ? int'(SAMPLE_MIN)
                                                   : $urandom_range(65535) - 32768;
                level_b = ($urandom_range(1) != 0) ? int'(SAMPLE_MAX)
                                                   : $urandom_range(65535) - 32768;
                if ($urandom_range(1) != 0)
                begin
                    value   = level_a;
                    level_a = level_b;
                    level_b = value;
                end
                amp = ($urandom_range(3) == 0) ? 32768 : $urandom_range(1, 32767);
            end
            case (kind)
                SEG_NOISE:
                    value = $urandom_range(65535) - 32768;
                SEG_SPEECH:
                begin
                    walk = walk + $urandom_range(2 * walk_step) - walk_step;
                    if (walk > 32767)
                        walk = 32767;
                    if (walk < -32768)
                        walk = -32768;
                    value = walk;
                end
                SEG_STEP:
                    value = (pos < seg_len / 2) ? level_a : level_b;
                SEG_NYQUIST:
                    value = pos[0] ? -amp : ((amp > 32767) ? 32767 : amp);
                SEG_QUIET:
                    value = $urandom_range(64) - 32;
                default:
                    value = 0;
            endcase
            last      = (frame_pos == FRAME_LEN - 1) || ($urandom_range(99) == 0);
            frame_pos = (frame_pos == FRAME_LEN - 1) ? 0 : frame_pos + 1;
            send_sample(value[SAMPLE_W-1:0], last);
            seg_left--;
            pos++;
        end
    endtask

    // -----------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------

    // field extremes, rail-to-rail alternation, full-scale steps after the
    // filter has settled on a rail, and frame markers mid-stream that must
    // not disturb the filter memory
    task automatic test_directed_extremes();
        send_sample(16'sd0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shaaaa, 1'b0);
        // settle on the negative rail, then the largest positive step
        for (int i = 0; i < 5; i++)
            send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        // and the largest negative step from the positive rail
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd0, 1'b1);
        drain_filter_output();
    endtask

    // random traffic under the three idling patterns of both sides
    task automatic test_random_with_gaps();
        tx_idle_pct = 32;
        rx_idle_pct = 49;
        run_speech_traffic(350);
        tx_idle_pct = 49;
        rx_idle_pct = 32;
        run_speech_traffic(350);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_speech_traffic(300);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and has to stall its input without losing samples
    task automatic test_output_backpressure();
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = HOLD_OFF_LEN;
        run_speech_traffic(40);
    endtask

    // sender stops until every output is out, then picks up where it left
    task automatic test_sender_pause();
        drain_filter_output();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        run_speech_traffic(60);
    endtask

    // -----------------------------------------------------------------
    // result side
    // -----------------------------------------------------------------

    task automatic report_mismatch(input string what, input int expected_val,
                                   input int actual_val);
        error_count++;
        $display("%0t ns: %s expected %0d, actual %0d",
                 $time, what, expected_val, actual_val);
    endtask

    // receiver ready pattern, with a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every master transaction is checked against the oldest booked output
    always @(posedge clk)
    begin
        filtered_sample_t oldest;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (filtered_q.size() == 0)
                report_mismatch("output transaction with none pending, sample",
                                0, $signed(m_axis_tdata));
            else
            begin
                oldest = filtered_q.pop_front();
                if (m_axis_tdata !== oldest.sample)
                    report_mismatch("sample_out", oldest.sample, $signed(m_axis_tdata));
                if (m_axis_tlast !== oldest.last)
                    report_mismatch("frame_last_out", oldest.last, m_axis_tlast);
            end
        end
    end

    // watchdog: a run with no transaction for too long is a failure
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        filter_state    = '0;
        error_count     = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = 0;
        stall_cycles    = 0;
        frame_pos       = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_random_with_gaps();
        test_output_backpressure();
        test_sender_pause();

        // wait for the last outputs, then idle to catch anything stray
        drain_filter_output();
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
